@@ rtl/uniform_catmull_rom_tessellator_top_defines.svh @@
// Assertion macros shared by the tessellator.
`ifndef UNIFORM_CATMULL_ROM_TESSELLATOR_TOP_DEFINES_SVH
`define UNIFORM_CATMULL_ROM_TESSELLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crt check failed");

// Next-cycle implication, checked out of reset.
`define CRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crt check failed");

`endif

@@ rtl/crt_pkg.sv @@
package crt_pkg;

  localparam int unsigned MAX_SUBDIVISION = 64;
  localparam int unsigned DIV_STEPS = 57;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WGT1, ST_WGT2, ST_WGT3, ST_MAC, ST_DLOAD,
    ST_DIV, ST_STORE, ST_CMP, ST_FLUSH, ST_UPD
  } crt_state_t;

  typedef struct packed {
    logic       accept;
    logic       wgt1;
    logic       wgt2;
    logic       wgt3;
    logic       k_clr;
    logic       k_inc;
    logic       mac_en;
    logic       mac_first;
    logic [1:0] sel_j;
    logic [1:0] sel_c;
    logic       div_load;
    logic       div_step;
    logic       store_pt;
    logic       take_pt;
    logic       emit;
    logic       emit_last;
    logic       upd;
  } crt_cmd_t;

  typedef struct packed {
    logic seen3;
    logic k_last;
    logic dup;
    logic pend;
    logic out_free;
  } crt_sts_t;

endpackage

@@ rtl/crt_in_if.sv @@
interface crt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               curve_end;

  modport source (output valid, point_x, point_y, point_z, curve_end, input ready);
  modport sink (input valid, point_x, point_y, point_z, curve_end, output ready);
endinterface

@@ rtl/crt_out_if.sv @@
interface crt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic signed [31:0] curve_z;
  logic               run_last;

  modport source (output valid, curve_x, curve_y, curve_z, run_last, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, run_last, output ready);
endinterface

@@ rtl/crt_dp.sv @@
module crt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  crt_pkg::crt_cmd_t cmd,
  output crt_pkg::crt_sts_t sts,
  crt_in_if.sink            in_pt,
  crt_out_if.source         out_pt
);
  import crt_pkg::*;

  logic [6:0]         sub_r;
  logic [6:0]         s_eff;
  logic [6:0]         k_r;
  logic [1:0]         seen_r;
  logic signed [31:0] win_r [3][3];
  logic signed [31:0] p3_r [3];
  logic               end_r;
  logic [11:0]        k2_r;
  logic [12:0]        s2_r;
  logic [17:0]        k3_r;
  logic [18:0]        s3_r;
  logic [17:0]        ks2_r;
  logic [17:0]        k2s_r;
  logic signed [21:0] w_r [4];
  logic signed [55:0] acc_r;
  logic signed [21:0] w_sel;
  logic signed [31:0] p_sel;
  logic signed [53:0] prod;
  logic [19:0]        den;
  logic [55:0]        abs_acc;
  logic [56:0]        dvd_r;
  logic [19:0]        rem_r;
  logic               neg_r;
  logic [20:0]        trial;
  logic               qbit;
  logic [31:0]        sat_val;
  logic signed [31:0] pt_r [3];
  logic signed [31:0] prev_r [3];
  logic               have_prev_r;
  logic               pend_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_last_r;

  // Configuration register and clamped subdivision.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 7'd8;
    end else if (cfg_wr_en) begin
      sub_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (sub_r == 7'd0) s_eff = 7'd1;
    else if (sub_r > 7'(MAX_SUBDIVISION)) s_eff = 7'(MAX_SUBDIVISION);
    else s_eff = sub_r;
  end

  // Input item capture and sample index.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p3_r[0] <= in_pt.point_x;
      p3_r[1] <= in_pt.point_y;
      p3_r[2] <= in_pt.point_z;
      end_r   <= in_pt.curve_end;
    end
    if (cmd.k_clr) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + 7'd1;
  end

  // Blending weights, built in the wgt1, wgt2 and wgt3 steps from small products.
  always_ff @(posedge clk) begin
    if (cmd.wgt1) begin
      k2_r <= 12'(k_r[5:0] * k_r[5:0]);
      s2_r <= 13'(s_eff * s_eff);
    end
    if (cmd.wgt2) begin
      k3_r  <= 18'(k2_r * k_r[5:0]);
      s3_r  <= 19'(s2_r * s_eff);
      ks2_r <= 18'(s2_r * k_r[5:0]);
      k2s_r <= 18'(k2_r * s_eff);
    end
    if (cmd.wgt3) begin
      w_r[0] <= -$signed({4'd0, ks2_r}) + $signed({3'd0, k2s_r, 1'b0})
                - $signed({4'd0, k3_r});
      w_r[1] <= $signed({2'd0, s3_r, 1'b0}) - 22'sd5 * $signed({4'd0, k2s_r})
                + 22'sd3 * $signed({4'd0, k3_r});
      w_r[2] <= $signed({4'd0, ks2_r}) + $signed({2'd0, k2s_r, 2'b00})
                - 22'sd3 * $signed({4'd0, k3_r});
      w_r[3] <= $signed({4'd0, k3_r}) - $signed({4'd0, k2s_r});
    end
  end

  // One weighted term per cycle into the accumulator.
  always_comb begin
    w_sel = w_r[cmd.sel_j];
    case (cmd.sel_j)
      2'd0:    p_sel = win_r[0][cmd.sel_c];
      2'd1:    p_sel = win_r[1][cmd.sel_c];
      2'd2:    p_sel = win_r[2][cmd.sel_c];
      default: p_sel = p3_r[cmd.sel_c];
    endcase
    prod = w_sel * p_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      if (cmd.mac_first) acc_r <= 56'(prod);
      else acc_r <= acc_r + 56'(prod);
    end
  end

  // Restoring divider: rounds the magnitude by adding half the denominator.
  assign den     = {1'b0, s3_r} << 1;
  assign abs_acc = acc_r[55] ? 56'(-acc_r) : 56'(acc_r);
  assign trial   = {rem_r, dvd_r[56]};
  assign qbit    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= {1'b0, abs_acc} + {38'd0, s3_r};
      rem_r <= '0;
      neg_r <= acc_r[55];
    end else if (cmd.div_step) begin
      rem_r <= qbit ? 20'(trial - {1'b0, den}) : trial[19:0];
      dvd_r <= {dvd_r[55:0], qbit};
    end
  end

  // Saturate the signed quotient to 32 bits.
  always_comb begin
    if (neg_r) begin
      if (dvd_r > 57'h0_8000_0000) sat_val = 32'h8000_0000;
      else sat_val = -dvd_r[31:0];
    end else begin
      if (dvd_r > 57'h0_7FFF_FFFF) sat_val = 32'h7FFF_FFFF;
      else sat_val = dvd_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_pt) pt_r[cmd.sel_c] <= sat_val;
  end

  // Window, held-point count and last point of the curve.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      have_prev_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        win_r[0][c] <= '0;
        win_r[1][c] <= '0;
        win_r[2][c] <= '0;
        prev_r[c]   <= '0;
      end
    end else begin
      if (cmd.take_pt) begin
        for (int c = 0; c < 3; c++) prev_r[c] <= pt_r[c];
        have_prev_r <= 1'b1;
        pend_r      <= 1'b1;
      end else if (cmd.emit && cmd.emit_last) begin
        pend_r <= 1'b0;
      end
      if (cmd.upd) begin
        if (end_r) begin
          seen_r      <= '0;
          have_prev_r <= 1'b0;
          for (int c = 0; c < 3; c++) begin
            win_r[0][c] <= '0;
            win_r[1][c] <= '0;
            win_r[2][c] <= '0;
            prev_r[c]   <= '0;
          end
        end else begin
          if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
          for (int c = 0; c < 3; c++) begin
            win_r[0][c] <= win_r[1][c];
            win_r[1][c] <= win_r[2][c];
            win_r[2][c] <= p3_r[c];
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pt.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_x_r    <= prev_r[0];
      out_y_r    <= prev_r[1];
      out_z_r    <= prev_r[2];
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_pt.valid    = out_valid_r;
  assign out_pt.curve_x  = out_x_r;
  assign out_pt.curve_y  = out_y_r;
  assign out_pt.curve_z  = out_z_r;
  assign out_pt.run_last = out_last_r;

  assign sts.seen3    = (seen_r == 2'd3);
  assign sts.k_last   = (k_r == s_eff - 7'd1);
  assign sts.dup      = have_prev_r && (pt_r[0] == prev_r[0]) && (pt_r[1] == prev_r[1])
                        && (pt_r[2] == prev_r[2]);
  assign sts.pend     = pend_r;
  assign sts.out_free = !out_valid_r || out_pt.ready;

endmodule

@@ rtl/crt_ctrl.sv @@
module crt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crt_pkg::crt_sts_t sts,
  output crt_pkg::crt_cmd_t cmd
);
  import crt_pkg::*;

  crt_state_t state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  logic [1:0] c_r, c_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      c_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      c_r     <= c_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencing of one item: per sample, weights, three coordinates, then compare; then flush and window update.
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    c_nxt     = c_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel_j = j_r;
    cmd.sel_c = c_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.k_clr  = 1'b1;
          state_nxt  = sts.seen3 ? ST_WGT1 : ST_UPD;
        end
      end
      ST_WGT1: begin
        cmd.wgt1  = 1'b1;
        state_nxt = ST_WGT2;
      end
      ST_WGT2: begin
        cmd.wgt2  = 1'b1;
        state_nxt = ST_WGT3;
      end
      ST_WGT3: begin
        cmd.wgt3  = 1'b1;
        j_nxt     = '0;
        c_nxt     = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_en    = 1'b1;
        cmd.mac_first = (j_r == 2'd0);
        j_nxt         = j_r + 2'd1;
        if (j_r == 2'd3) state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store_pt = 1'b1;
        if (c_r == 2'd2) begin
          c_nxt     = '0;
          state_nxt = ST_CMP;
        end else begin
          c_nxt     = c_r + 2'd1;
          state_nxt = ST_MAC;
        end
      end
      ST_CMP: begin
        if (sts.dup || !sts.pend || sts.out_free) begin
          if (!sts.dup) begin
            cmd.take_pt = 1'b1;
            cmd.emit    = sts.pend;
          end
          if (sts.k_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_WGT1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend) begin
          state_nxt = ST_UPD;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/uniform_catmull_rom_tessellator_top.sv @@
// A point that only fills the window goes straight to the window update;
// otherwise each sample takes the weight steps, then per coordinate four
// multiply-accumulate terms and a 57-step divide, for each of the samples.
// Throughput: one item at a time, set by the shared multiplier and divider.
// Reset: synchronous active-low rst_n empties the window, sets subdivision to 8.
`include "uniform_catmull_rom_tessellator_top_defines.svh"

module uniform_catmull_rom_tessellator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  crt_in_if.sink     in_pt,
  crt_out_if.source  out_pt
);
  import crt_pkg::*;

  crt_cmd_t cmd;
  crt_sts_t sts;
  logic     in_ready;

  // Sequencer.
  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  crt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .in_pt       (in_pt),
    .out_pt      (out_pt)
  );

  assign in_pt.ready = in_ready;

  // A new item is never taken while a point of the last one is still held back from the output register.
  `CRT_ASSERT_NOW(a_ready_no_pend, in_ready, !sts.pend)
  // Points are written to the output register only when it can take them.
  `CRT_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free)
  // The block is not ready in the cycle after it accepts an item.
  `CRT_ASSERT_NEXT(a_busy_after_accept, in_pt.valid && in_ready, !in_ready)

endmodule
